>>> hdl/crmr_pkg.sv
// crmr_pkg: payload types and fixed widths for channel_running_mean_rms.
// No dependencies.
`default_nettype none
package crmr_pkg;
    localparam int CHAN_W  = 12;
    localparam int SAMP_W  = 20;
    localparam int MEAN_W  = 32;
    localparam int Q_W     = 64;
    localparam int CNT_W   = 16;
    localparam logic [CNT_W-1:0] COUNT_FULL = 16'hFFFF;
    localparam logic [Q_W-1:0]   VAR_LIMIT  = 64'h0000_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [CHAN_W-1:0] channel_index;
        logic [SAMP_W-1:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_channel;
        logic [MEAN_W-1:0] mean_value;
        logic [MEAN_W-1:0] rms_value;
        logic [CNT_W-1:0]  sample_count;
        logic              count_saturated;
    } out_item_t;
endpackage
`default_nettype wire

>>> hdl/crmr_div.sv
// crmr_div: restoring divider, one quotient bit per cycle (64 / 16 bit).
// Depends on crmr_pkg.
`default_nettype none
module crmr_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [crmr_pkg::Q_W-1:0]   dividend,
    input  wire logic [crmr_pkg::CNT_W-1:0] divisor,
    output logic                           done,
    output logic [crmr_pkg::Q_W-1:0]        quotient
);
    logic [crmr_pkg::Q_W-1:0]   quo_reg, quo_next;
    logic [crmr_pkg::CNT_W:0]   rem_reg, rem_next;
    logic [crmr_pkg::CNT_W-1:0] den_reg, den_next;
    logic [6:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [crmr_pkg::CNT_W+1:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, quo_reg[crmr_pkg::Q_W-1]} - {2'b00, den_reg};
            if (!trial[crmr_pkg::CNT_W+1])
            begin
                rem_next = trial[crmr_pkg::CNT_W:0];
                quo_next = {quo_reg[crmr_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[crmr_pkg::CNT_W-1:0], quo_reg[crmr_pkg::Q_W-1]};
                quo_next = {quo_reg[crmr_pkg::Q_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

>>> hdl/crmr_mul.sv
// crmr_mul: shift-add multiplier, one multiplier bit per cycle (32 x 32).
// Depends on crmr_pkg.
`default_nettype none
module crmr_mul (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [crmr_pkg::MEAN_W-1:0] a,
    input  wire logic [crmr_pkg::MEAN_W-1:0] b,
    output logic                            done,
    output logic [crmr_pkg::Q_W-1:0]         product
);
    logic [crmr_pkg::Q_W-1:0]    acc_reg, acc_next;
    logic [crmr_pkg::Q_W-1:0]    mcand_reg, mcand_next;
    logic [crmr_pkg::MEAN_W-1:0] mplier_reg, mplier_next;
    logic [5:0]                  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = {{(crmr_pkg::Q_W-crmr_pkg::MEAN_W){1'b0}}, a};
            mplier_next = b;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = {mcand_reg[crmr_pkg::Q_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[crmr_pkg::MEAN_W-1:1]};
            cnt_next    = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule
`default_nettype wire

>>> hdl/crmr_sqrt.sv
// crmr_sqrt: digit-by-digit integer square root, one result bit per cycle.
// Depends on crmr_pkg.
`default_nettype none
module crmr_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [crmr_pkg::Q_W-1:0]    radicand,
    output logic                            done,
    output logic [crmr_pkg::MEAN_W-1:0]      root
);
    logic [crmr_pkg::Q_W-1:0]    x_reg, x_next;
    logic [crmr_pkg::MEAN_W+1:0] rem_reg, rem_next;
    logic [crmr_pkg::MEAN_W-1:0] root_reg, root_next;
    logic [5:0]                  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [crmr_pkg::MEAN_W+1:0] shifted;
    logic [crmr_pkg::MEAN_W+1:0] trial;

    always_comb
    begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[crmr_pkg::MEAN_W-1:0], x_reg[crmr_pkg::Q_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        if (start)
        begin
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = {x_reg[crmr_pkg::Q_W-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[crmr_pkg::MEAN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[crmr_pkg::MEAN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

>>> hdl/channel_running_mean_rms.sv
// channel_running_mean_rms: per-channel running mean and rms (Welford update).
// Depends on crmr_pkg, crmr_div, crmr_mul, crmr_sqrt.
//
//   channel | direction | payload    | handshake
//   in      | into      | in_item_t  | in_valid / in_ready
//   out     | out of    | out_item_t | out_valid / out_ready
//
// After acceptance a request reduces the channel to a store row, reads and loads
// the store entry, then computes the mean quotient, the deviation product, the
// variance quotient and the root, and presents the result. A saturated channel
// skips the first quotient and the product. After reset a clearing pass walks
// every store row with in_ready low.
// A finished result waits for the output register to be free; in_ready stays low
// from acceptance until the result has been moved into that register.
`default_nettype none
module channel_running_mean_rms #(
    parameter int CHANNELS    = 4096,
    parameter int SAMPLE_BITS = 20
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire crmr_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output crmr_pkg::out_item_t      out_data
);
    localparam int ROW_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENT_W = crmr_pkg::CNT_W + crmr_pkg::MEAN_W + crmr_pkg::Q_W;
    localparam logic [16:0] CH_LIM    = 17'(CHANNELS);
    localparam logic [63:0] SAMP_MASK = (64'd1 << SAMPLE_BITS) - 64'd1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_ROW, ST_READ, ST_LOAD, ST_START, ST_DIV1, ST_MUL,
        ST_DIV2, ST_ROOT, ST_EMIT
    } state_t;

    state_t state_reg;

    // entry store: one write and one registered read port
    logic [ENT_W-1:0] store_mem [CHANNELS];
    logic [ENT_W-1:0] rd_data_reg;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;

    logic [ROW_W:0]   clr_reg;
    logic [ROW_W-1:0] row_reg;
    logic [crmr_pkg::CHAN_W-1:0] chan_reg;
    logic [crmr_pkg::CHAN_W-1:0] chan_sh_reg;
    logic [crmr_pkg::CHAN_W-1:0] rowrem_reg;
    logic [3:0]                  rowcnt_reg;
    logic [crmr_pkg::MEAN_W-1:0] v12_reg;
    logic [crmr_pkg::CNT_W-1:0]  n_reg;
    logic [crmr_pkg::MEAN_W-1:0] m_reg;
    logic [crmr_pkg::Q_W-1:0]    q_reg;
    logic [crmr_pkg::MEAN_W-1:0] dmag_reg;
    logic                        dneg_reg;
    logic                        sat_reg;
    logic                        out_valid_reg;
    crmr_pkg::out_item_t         out_reg;

    logic                        div_start, mul_start, sqrt_start;
    logic [crmr_pkg::Q_W-1:0]    div_dend;
    logic                        div_done, mul_done, sqrt_done;
    logic [crmr_pkg::Q_W-1:0]    div_quo, mul_prod;
    logic [crmr_pkg::MEAN_W-1:0] sqrt_root;

    // combinational helpers
    logic [crmr_pkg::MEAN_W:0]   newm_w;
    logic [crmr_pkg::MEAN_W-1:0] newm;
    logic [crmr_pkg::MEAN_W-1:0] emag;
    logic [crmr_pkg::Q_W-1:0]    prod_sh;
    logic [crmr_pkg::Q_W:0]      qsum;
    logic [crmr_pkg::Q_W-1:0]    q_upd;
    logic [crmr_pkg::Q_W-1:0]    var_c;
    logic [crmr_pkg::MEAN_W-1:0] samp_masked;
    logic [crmr_pkg::CHAN_W:0]   row_shift;
    logic [crmr_pkg::CHAN_W:0]   row_step;
    logic [crmr_pkg::CNT_W-1:0]  ld_cnt;
    logic [crmr_pkg::MEAN_W-1:0] ld_mean;

    always_comb
    begin
        samp_masked = {{(crmr_pkg::MEAN_W-crmr_pkg::SAMP_W){1'b0}},
                       in_data.sample_value & SAMP_MASK[crmr_pkg::SAMP_W-1:0]};
    end

    // row = channel mod CHANNELS, one restoring step per cycle, MSB first
    always_comb
    begin
        row_shift = {rowrem_reg, chan_sh_reg[crmr_pkg::CHAN_W-1]};
        if ({4'd0, row_shift} >= CH_LIM)
            row_step = row_shift - CH_LIM[crmr_pkg::CHAN_W:0];
        else
            row_step = row_shift;
    end

    assign ld_cnt  = rd_data_reg[ENT_W-1 -: crmr_pkg::CNT_W];
    assign ld_mean = rd_data_reg[crmr_pkg::Q_W +: crmr_pkg::MEAN_W];

    always_comb
    begin
        if (dneg_reg)
            newm_w = {1'b0, m_reg} - {1'b0, div_quo[crmr_pkg::MEAN_W-1:0]};
        else
            newm_w = {1'b0, m_reg} + {1'b0, div_quo[crmr_pkg::MEAN_W-1:0]};
        newm = (newm_w[crmr_pkg::MEAN_W] && !dneg_reg) ? '1 : newm_w[crmr_pkg::MEAN_W-1:0];
        emag = (v12_reg >= newm) ? v12_reg - newm : newm - v12_reg;
        prod_sh = {16'd0, mul_prod[crmr_pkg::Q_W-1:16]};
        qsum = {1'b0, q_reg} + {1'b0, prod_sh};
        q_upd = qsum[crmr_pkg::Q_W] ? '1 : qsum[crmr_pkg::Q_W-1:0];
        var_c = (div_quo > crmr_pkg::VAR_LIMIT) ? crmr_pkg::VAR_LIMIT : div_quo;
    end

    // first quotient: |d| / n; second: q' / n (q' = q plus the product shifted down 16 bits; q when saturated)
    assign div_dend = (state_reg == ST_START) ? {32'd0, dmag_reg} :
                      (sat_reg ? q_reg : q_upd);

    crmr_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dend),
        .divisor(n_reg), .done(div_done), .quotient(div_quo)
    );
    // the product starts while the quotient is on the divider output,
    // so emag = |v12 - m'| comes from newm
    crmr_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(dmag_reg), .b(emag),
        .done(mul_done), .product(mul_prod)
    );
    crmr_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sqrt_start),
        .radicand({var_c[crmr_pkg::Q_W-17:0], 16'd0}),
        .done(sqrt_done), .root(sqrt_root)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        div_start  = 1'b0;
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = row_reg;
        wr_data    = {n_reg, m_reg, q_reg};
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg[ROW_W-1:0];
                wr_data = '0;
            end
            ST_START:
                div_start = !sat_reg;
            ST_DIV1:
                mul_start = div_done;
            ST_MUL:
                div_start = mul_done || sat_reg;
            ST_DIV2:
                sqrt_start = div_done;
            ST_ROOT:
                wr_en = sqrt_done && !sat_reg;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
        rd_data_reg <= store_mem[row_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_EMIT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + (ROW_W+1)'(1);
                    if (clr_reg == (ROW_W+1)'(CHANNELS - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                    if (in_valid)
                    begin
                        chan_reg    <= in_data.channel_index;
                        chan_sh_reg <= in_data.channel_index;
                        rowrem_reg  <= '0;
                        rowcnt_reg  <= '0;
                        v12_reg     <= samp_masked << 12;
                        state_reg   <= ST_ROW;
                    end
                ST_ROW:
                begin
                    rowrem_reg  <= row_step[crmr_pkg::CHAN_W-1:0];
                    chan_sh_reg <= {chan_sh_reg[crmr_pkg::CHAN_W-2:0], 1'b0};
                    rowcnt_reg  <= rowcnt_reg + 4'd1;
                    if (rowcnt_reg == 4'(crmr_pkg::CHAN_W - 1))
                    begin
                        row_reg   <= ROW_W'(row_step);
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                    state_reg <= ST_LOAD;
                ST_LOAD:
                begin
                    m_reg     <= ld_mean;
                    q_reg     <= rd_data_reg[crmr_pkg::Q_W-1:0];
                    sat_reg   <= (ld_cnt == crmr_pkg::COUNT_FULL);
                    n_reg     <= (ld_cnt == crmr_pkg::COUNT_FULL) ? ld_cnt : ld_cnt + 16'd1;
                    state_reg <= ST_START;
                    // dmag and direction of the step
                    if (v12_reg < ld_mean)
                    begin
                        dneg_reg <= 1'b1;
                        dmag_reg <= ld_mean - v12_reg;
                    end
                    else
                    begin
                        dneg_reg <= 1'b0;
                        dmag_reg <= v12_reg - ld_mean;
                    end
                end
                ST_START:
                    state_reg <= ST_DIV1;
                ST_DIV1:
                    if (sat_reg)
                        state_reg <= ST_MUL;
                    else if (div_done)
                    begin
                        m_reg     <= newm;
                        state_reg <= ST_MUL;
                    end
                ST_MUL:
                    if (sat_reg || mul_done)
                    begin
                        if (!sat_reg)
                            q_reg <= q_upd;
                        state_reg <= ST_DIV2;
                    end
                ST_DIV2:
                    if (div_done)
                        state_reg <= ST_ROOT;
                ST_ROOT:
                    if (sqrt_done)
                        state_reg <= ST_EMIT;
                ST_EMIT:
                    // root stays on the sqrt output until its next start
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.out_channel     <= chan_reg;
                        out_reg.mean_value      <= m_reg;
                        out_reg.rms_value       <= (n_reg == '0) ? '0 : sqrt_root;
                        out_reg.sample_count    <= n_reg;
                        out_reg.count_saturated <= sat_reg;
                        state_reg               <= ST_IDLE;
                    end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // a result is never overwritten before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("pending result changed");
    // no request is taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !in_ready)
        else $error("request taken while clearing");
    // a saturated result reports the full count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.count_saturated |-> out_data.sample_count == crmr_pkg::COUNT_FULL)
        else $error("saturation flag without full count");
endmodule
`default_nettype wire
